// ----- rtl/max_tracking_stack_macros.svh -----
// Assertion helpers for the max tracking stack.
`ifndef MAX_TRACKING_STACK_MACROS_SVH
`define MAX_TRACKING_STACK_MACROS_SVH

`ifndef SYNTHESIS
`define MTS_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MTS_ASSERT(label, clk, rst_n, expr)
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CNT_W_DEF      = $clog2(DEPTH_DEF + 1);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// memory strobes from controller to store
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

// ----- rtl/mts_req_if.sv -----
interface mts_req_if #(
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- rtl/mts_rsp_if.sv -----
interface mts_rsp_if #(
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W      = mts_pkg::CNT_W_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] top_value;
	logic signed [DATA_WIDTH-1:0] max_value;
	logic [CNT_W-1:0]             entry_count;
	logic [1:0]                   status;

	modport source (output valid, output top_value, output max_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input top_value, input max_value,
		input entry_count, input status, output ready);
endinterface

// ----- rtl/mts_store.sv -----
`include "max_tracking_stack_macros.svh"

module mts_store #(
	parameter int DEPTH      = mts_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  mts_pkg::mem_ctl_t            ctl,
	input  logic [AW-1:0]                waddr,
	input  logic signed [DATA_WIDTH-1:0] wvalue,
	input  logic signed [DATA_WIDTH-1:0] wmax,
	input  logic [AW-1:0]                raddr,
	output logic signed [DATA_WIDTH-1:0] rvalue,
	output logic signed [DATA_WIDTH-1:0] rmax
);
	import mts_pkg::*;

	// value and running max of one depth share a word
	logic [2*DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [2*DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[waddr] <= {wvalue, wmax};
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rvalue = $signed(rdata_q[2*DATA_WIDTH-1:DATA_WIDTH]);
	assign rmax   = $signed(rdata_q[DATA_WIDTH-1:0]);

	`MTS_ASSERT(a_no_wr_rd_same_cycle, clk, 1'b1, !(ctl.wr && ctl.rd))

endmodule

// ----- rtl/mts_ctrl.sv -----
`include "max_tracking_stack_macros.svh"

module mts_ctrl #(
	parameter int DEPTH      = mts_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mts_req_if.sink                      req,
	mts_rsp_if.source                    rsp,
	output mts_pkg::mem_ctl_t            mem_ctl,
	output logic [AW-1:0]                waddr,
	output logic signed [DATA_WIDTH-1:0] wvalue,
	output logic signed [DATA_WIDTH-1:0] wmax,
	output logic [AW-1:0]                raddr,
	input  logic signed [DATA_WIDTH-1:0] rvalue,
	input  logic signed [DATA_WIDTH-1:0] rmax
);
	import mts_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} state_t;

	state_t                       state_q, state_d;
	logic [CW-1:0]                count_q, count_d;
	logic signed [DATA_WIDTH-1:0] top_q, top_d;
	logic signed [DATA_WIDTH-1:0] tmax_q, tmax_d;

	logic                         ov_q;
	logic signed [DATA_WIDTH-1:0] o_top_q, o_max_q;
	logic [CW-1:0]                o_cnt_q;
	status_t                      o_st_q;

	logic                         acc, emit;
	logic signed [DATA_WIDTH-1:0] e_top, e_max;
	status_t                      e_st;
	logic signed [DATA_WIDTH-1:0] new_max;
	logic                         is_empty, is_full;
	logic [CW-1:0]                below_idx;

	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(DEPTH));
	assign below_idx = count_q - CW'(2);
	assign new_max   = (is_empty || (req.value > tmax_q)) ? req.value : tmax_q;

	assign req.ready = (state_q == S_IDLE) && (!ov_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	assign waddr  = count_q[AW-1:0];
	assign wvalue = req.value;
	assign wmax   = new_max;
	assign raddr  = below_idx[AW-1:0];

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		top_d       = top_q;
		tmax_d      = tmax_q;
		mem_ctl     = '0;
		emit        = 1'b0;
		e_st        = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.op)
						OP_PUSH: begin
							emit = 1'b1;
							if (is_full) begin
								e_st = ST_FULL;
							end else begin
								mem_ctl.wr = 1'b1;
								top_d      = req.value;
								tmax_d     = new_max;
								count_d    = count_q + CW'(1);
							end
						end
						OP_POP: begin
							if (is_empty) begin
								emit = 1'b1;
								e_st = ST_EMPTY;
							end else if (count_q == CW'(1)) begin
								emit    = 1'b1;
								count_d = '0;
							end else begin
								// new top comes back from the store next cycle
								mem_ctl.rd = 1'b1;
								count_d    = count_q - CW'(1);
								state_d    = S_POP;
							end
						end
						default: begin
							emit = 1'b1;
							if (is_empty) begin
								e_st = ST_EMPTY;
							end
						end
					endcase
				end
			end
			S_POP: begin
				top_d   = rvalue;
				tmax_d  = rmax;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		e_top = (count_d == '0) ? '0 : top_d;
		e_max = (count_d == '0) ? '0 : tmax_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q  <= top_d;
		tmax_q <= tmax_d;
		if (emit) begin
			o_top_q <= e_top;
			o_max_q <= e_max;
			o_cnt_q <= count_d;
			o_st_q  <= e_st;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.top_value   = o_top_q;
	assign rsp.max_value   = o_max_q;
	assign rsp.entry_count = o_cnt_q;
	assign rsp.status      = o_st_q;

	`MTS_ASSERT(a_count_in_range, clk, arst_n, count_q <= CW'(DEPTH))
	`MTS_ASSERT(a_pop_slot_free, clk, arst_n, (state_q != S_POP) || !ov_q)
	`MTS_ASSERT_NEXT(a_read_then_pop, clk, arst_n, mem_ctl.rd, state_q == S_POP)
	`MTS_ASSERT_NEXT(a_pop_emits, clk, arst_n, state_q == S_POP, ov_q && state_q == S_IDLE)

endmodule

// ----- rtl/max_tracking_stack.sv -----
// Channel | Dir | Beat fields
// --------+-----+-----------------------------------------------
// req     | in  | op, value
// rsp     | out | top_value, max_value, entry_count, status
//
// One beat in gives one beat out. Push and query finish without a wait
// state; a pop that leaves entries behind passes through S_POP, since the
// stack memory returns the new top from a registered read. Top and
// running max sit in registers; arst_n empties the stack, not the memory.
// A finished result waits in the output register while the next beat is
// taken; rsp stalls hold req off only when that register is still full.
module max_tracking_stack #(
	parameter int DEPTH      = mts_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	localparam int AW = $clog2(DEPTH);

	mem_ctl_t                     mem_ctl;
	logic [AW-1:0]                waddr, raddr;
	logic signed [DATA_WIDTH-1:0] wvalue, wmax, rvalue, rmax;

	mts_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_ctl (mem_ctl),
		.waddr   (waddr),
		.wvalue  (wvalue),
		.wmax    (wmax),
		.raddr   (raddr),
		.rvalue  (rvalue),
		.rmax    (rmax)
	);

	mts_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk    (clk),
		.ctl    (mem_ctl),
		.waddr  (waddr),
		.wvalue (wvalue),
		.wmax   (wmax),
		.raddr  (raddr),
		.rvalue (rvalue),
		.rmax   (rmax)
	);

endmodule
